// ----- design/spt_pkg.sv -----
// Shared types and constants for the segment proximity test pipeline.
// No dependencies; used by every module of the block.
package spt_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd768;
    localparam int DIST_WIDTH      = 16;

    // How the result of one request is decided.
    typedef enum logic [2:0] {
        KIND_END1,
        KIND_END2,
        KIND_MISS,
        KIND_NEARV,
        KIND_NEARH,
        KIND_CALC
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg_x;
        logic  neg_y;
    } ctl_t;

endpackage

// ----- design/spt_front.sv -----
// Front pipeline: differences, endpoint/box classification, products and the
// rounded-division operands. Depends on spt_pkg.
module spt_front #(
    parameter int CW = spt_pkg::COORD_WIDTH_DEF,
    parameter int FB = spt_pkg::FRAC_BITS_DEF,
    parameter int NUMW = 3 * CW + 3,
    parameter int DENW = 2 * CW + 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [CW-1:0]              x1,
    input  logic signed [CW-1:0]              y1,
    input  logic signed [CW-1:0]              x2,
    input  logic signed [CW-1:0]              y2,
    input  logic signed [CW-1:0]              xp,
    input  logic signed [CW-1:0]              yp,
    input  logic [spt_pkg::TOL_WIDTH-1:0]     tol,
    output spt_pkg::ctl_t                     ctl_out,
    output logic [NUMW-1:0]                   num_x,
    output logic [NUMW-1:0]                   num_y,
    output logic [DENW-1:0]                   den2,
    output logic signed [CW-1:0]              bx_out,
    output logic signed [CW-1:0]              by_out,
    output logic signed [CW-1:0]              px_out,
    output logic signed [CW-1:0]              py_out,
    output logic [spt_pkg::TOL_WIDTH-1:0]     tol_out
);

    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int MW  = 2 * CW + 2;
    localparam int HL  = MW / 2;
    localparam int HH  = MW - HL;
    localparam int CMW = (DW > 17) ? DW : 17;
    localparam int TW  = spt_pkg::TOL_WIDTH;

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        mag = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    // ---------------- stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] a1_reg, b1_reg, ux1_reg, uy1_reg, vx1_reg, vy1_reg;
    logic signed [CW-1:0] x11_reg, y11_reg, x21_reg, y21_reg, xp1_reg, yp1_reg;
    logic [TW-1:0]        t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg  <= $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
            b1_reg  <= $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
            ux1_reg <= $signed({xp[CW-1], xp}) - $signed({x1[CW-1], x1});
            uy1_reg <= $signed({yp[CW-1], yp}) - $signed({y1[CW-1], y1});
            vx1_reg <= $signed({xp[CW-1], xp}) - $signed({x2[CW-1], x2});
            vy1_reg <= $signed({yp[CW-1], yp}) - $signed({y2[CW-1], y2});
            x11_reg <= x1;
            y11_reg <= y1;
            x21_reg <= x2;
            y21_reg <= y2;
            xp1_reg <= xp;
            yp1_reg <= yp;
            t1_reg  <= tol;
        end
    end

    // ---------------- stage 2: classify, products
    logic [CMW-1:0] t_ext, one_ext;
    logic [CMW-1:0] ma_e, mb_e, mux_e, muy_e, mvx_e, mvy_e;
    logic [DW-1:0]  ma, mb, mux, muy;
    logic           e1, e2, outside, nearv, nearh;
    spt_pkg::kind_t kind2;
    logic signed [CW-1:0] bx2, by2;

    always_comb begin
        ma      = mag(a1_reg);
        mb      = mag(b1_reg);
        mux     = mag(ux1_reg);
        muy     = mag(uy1_reg);
        ma_e    = CMW'(ma);
        mb_e    = CMW'(mb);
        mux_e   = CMW'(mux);
        muy_e   = CMW'(muy);
        mvx_e   = CMW'(mag(vx1_reg));
        mvy_e   = CMW'(mag(vy1_reg));
        t_ext   = CMW'(t1_reg);
        one_ext = CMW'(1) << FB;
        e1 = (mux_e <= t_ext) && (muy_e <= t_ext);
        e2 = (mvx_e <= t_ext) && (mvy_e <= t_ext);
        // outside the widened box when both endpoint offsets exceed tol on one side
        outside = (ux1_reg[DW-1] && mux_e > t_ext && vx1_reg[DW-1] && mvx_e > t_ext)
               || (!ux1_reg[DW-1] && mux_e > t_ext && !vx1_reg[DW-1] && mvx_e > t_ext)
               || (uy1_reg[DW-1] && muy_e > t_ext && vy1_reg[DW-1] && mvy_e > t_ext)
               || (!uy1_reg[DW-1] && muy_e > t_ext && !vy1_reg[DW-1] && mvy_e > t_ext);
        nearv = ma_e <= one_ext;
        nearh = mb_e <= one_ext;
        bx2 = x11_reg;
        by2 = y11_reg;
        if (e1) begin
            kind2 = spt_pkg::KIND_END1;
        end else if (e2) begin
            kind2 = spt_pkg::KIND_END2;
            bx2   = x21_reg;
            by2   = y21_reg;
        end else if (outside) begin
            kind2 = spt_pkg::KIND_MISS;
        end else if (nearv) begin
            kind2 = spt_pkg::KIND_NEARV;
            by2   = yp1_reg;
        end else if (nearh) begin
            kind2 = spt_pkg::KIND_NEARH;
            bx2   = xp1_reg;
        end else begin
            kind2 = spt_pkg::KIND_CALC;
        end
    end

    logic                 v2_reg;
    spt_pkg::kind_t       k2_reg;
    logic [PW-1:0]        pax_reg, pby_reg, paa_reg, pbb_reg;
    logic                 sax_reg, sby_reg, sa2_reg, sb2_reg;
    logic [DW-1:0]        ma2_reg, mb2_reg;
    logic signed [CW-1:0] bx2_reg, by2_reg, xp2_reg, yp2_reg;
    logic [TW-1:0]        t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k2_reg  <= kind2;
            pax_reg <= PW'(ma) * PW'(mux);
            pby_reg <= PW'(mb) * PW'(muy);
            paa_reg <= PW'(ma) * PW'(ma);
            pbb_reg <= PW'(mb) * PW'(mb);
            sax_reg <= a1_reg[DW-1] ^ ux1_reg[DW-1];
            sby_reg <= b1_reg[DW-1] ^ uy1_reg[DW-1];
            sa2_reg <= a1_reg[DW-1];
            sb2_reg <= b1_reg[DW-1];
            ma2_reg <= ma;
            mb2_reg <= mb;
            bx2_reg <= bx2;
            by2_reg <= by2;
            xp2_reg <= xp1_reg;
            yp2_reg <= yp1_reg;
            t2_reg  <= t1_reg;
        end
    end

    // ---------------- stage 3: dot product n and squared length d
    logic signed [MW:0] tx, ty;

    always_comb begin
        tx = $signed({1'b0, pax_reg[MW-1:0]});
        ty = $signed({1'b0, pby_reg[MW-1:0]});
    end

    logic                 v3_reg;
    spt_pkg::kind_t       k3_reg;
    logic signed [MW:0]   n3_reg;
    logic [MW-1:0]        d3_reg;
    logic                 sa3_reg, sb3_reg;
    logic [DW-1:0]        ma3_reg, mb3_reg;
    logic signed [CW-1:0] bx3_reg, by3_reg, xp3_reg, yp3_reg;
    logic [TW-1:0]        t3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k3_reg  <= k2_reg;
            n3_reg  <= (sax_reg ? -tx : tx) + (sby_reg ? -ty : ty);
            d3_reg  <= paa_reg[MW-1:0] + pbb_reg[MW-1:0];
            sa3_reg <= sa2_reg;
            sb3_reg <= sb2_reg;
            ma3_reg <= ma2_reg;
            mb3_reg <= mb2_reg;
            bx3_reg <= bx2_reg;
            by3_reg <= by2_reg;
            xp3_reg <= xp2_reg;
            yp3_reg <= yp2_reg;
            t3_reg  <= t2_reg;
        end
    end

    // ---------------- stage 4: split products |a|*|n|, |b|*|n|
    logic [MW-1:0] nmag;

    always_comb begin
        nmag = n3_reg[MW] ? MW'(-n3_reg) : MW'(n3_reg);
    end

    logic                 v4_reg;
    spt_pkg::kind_t       k4_reg;
    logic [DW+HL-1:0]     axl_reg, bxl_reg;
    logic [DW+HH-1:0]     axh_reg, bxh_reg;
    logic [MW-1:0]        d4_reg;
    logic                 nx4_reg, ny4_reg;
    logic signed [CW-1:0] bx4_reg, by4_reg, xp4_reg, yp4_reg;
    logic [TW-1:0]        t4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k4_reg  <= k3_reg;
            axl_reg <= (DW+HL)'(ma3_reg) * (DW+HL)'(nmag[HL-1:0]);
            axh_reg <= (DW+HH)'(ma3_reg) * (DW+HH)'(nmag[MW-1:HL]);
            bxl_reg <= (DW+HL)'(mb3_reg) * (DW+HL)'(nmag[HL-1:0]);
            bxh_reg <= (DW+HH)'(mb3_reg) * (DW+HH)'(nmag[MW-1:HL]);
            d4_reg  <= d3_reg;
            nx4_reg <= n3_reg[MW] ^ sa3_reg;
            ny4_reg <= n3_reg[MW] ^ sb3_reg;
            bx4_reg <= bx3_reg;
            by4_reg <= by3_reg;
            xp4_reg <= xp3_reg;
            yp4_reg <= yp3_reg;
            t4_reg  <= t3_reg;
        end
    end

    // ---------------- stage 5: rounding operands 2m+d over 2d
    logic [NUMW-1:0] mx, my;

    always_comb begin
        mx = NUMW'(axl_reg) + (NUMW'(axh_reg) << HL);
        my = NUMW'(bxl_reg) + (NUMW'(bxh_reg) << HL);
    end

    logic                 v5_reg;
    spt_pkg::kind_t       k5_reg;
    logic                 nx5_reg, ny5_reg;
    logic [NUMW-1:0]      numx_reg, numy_reg;
    logic [DENW-1:0]      den_reg;
    logic signed [CW-1:0] bx5_reg, by5_reg, xp5_reg, yp5_reg;
    logic [TW-1:0]        t5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k5_reg   <= k4_reg;
            nx5_reg  <= nx4_reg;
            ny5_reg  <= ny4_reg;
            numx_reg <= (mx << 1) + NUMW'(d4_reg);
            numy_reg <= (my << 1) + NUMW'(d4_reg);
            den_reg  <= DENW'({d4_reg, 1'b0});
            bx5_reg  <= bx4_reg;
            by5_reg  <= by4_reg;
            xp5_reg  <= xp4_reg;
            yp5_reg  <= yp4_reg;
            t5_reg   <= t4_reg;
        end
    end

    assign ctl_out = '{valid: v5_reg, kind: k5_reg, neg_x: nx5_reg, neg_y: ny5_reg};
    assign num_x   = numx_reg;
    assign num_y   = numy_reg;
    assign den2    = den_reg;
    assign bx_out  = bx5_reg;
    assign by_out  = by5_reg;
    assign px_out  = xp5_reg;
    assign py_out  = yp5_reg;
    assign tol_out = t5_reg;

endmodule

// ----- design/spt_div.sv -----
// Pipelined restoring divider: two numerators over one shared divisor,
// one quotient bit per stage. Depends on spt_pkg for the control struct.
module spt_div #(
    parameter int NUMW = 3 * spt_pkg::COORD_WIDTH_DEF + 3,
    parameter int DENW = 2 * spt_pkg::COORD_WIDTH_DEF + 3,
    parameter int QW   = spt_pkg::COORD_WIDTH_DEF + 2,
    parameter int SBW  = 4 * spt_pkg::COORD_WIDTH_DEF + spt_pkg::TOL_WIDTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  spt_pkg::ctl_t   ctl_in,
    input  logic [NUMW-1:0] num_x,
    input  logic [NUMW-1:0] num_y,
    input  logic [DENW-1:0] den,
    input  logic [SBW-1:0]  sb_in,
    output spt_pkg::ctl_t   ctl_out,
    output logic [QW-1:0]   q_x,
    output logic [QW-1:0]   q_y,
    output logic [SBW-1:0]  sb_out
);

    localparam int RW = DENW + QW;

    logic            v_reg  [0:QW-1];
    spt_pkg::ctl_t   c_reg  [0:QW-1];
    logic [QW-1:0]   qx_reg [0:QW-1];
    logic [QW-1:0]   qy_reg [0:QW-1];
    logic [SBW-1:0]  sb_reg [0:QW-1];
    logic [RW-1:0]   rx_reg [0:QW-2];
    logic [RW-1:0]   ry_reg [0:QW-2];
    logic [DENW-1:0] d_reg  [0:QW-2];

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            localparam int J = QW - 1 - k;
            logic            v_in;
            spt_pkg::ctl_t   c_in;
            logic [RW-1:0]   rx_in, ry_in, dsh;
            logic [QW-1:0]   qx_in, qy_in;
            logic [DENW-1:0] d_in;
            logic [SBW-1:0]  sb_i;
            logic            ge_x, ge_y;

            if (k == 0) begin : g_first
                assign v_in  = ctl_in.valid;
                assign c_in  = ctl_in;
                assign rx_in = RW'(num_x);
                assign ry_in = RW'(num_y);
                assign qx_in = '0;
                assign qy_in = '0;
                assign d_in  = den;
                assign sb_i  = sb_in;
            end else begin : g_next
                assign v_in  = v_reg[k-1];
                assign c_in  = c_reg[k-1];
                assign rx_in = rx_reg[k-1];
                assign ry_in = ry_reg[k-1];
                assign qx_in = qx_reg[k-1];
                assign qy_in = qy_reg[k-1];
                assign d_in  = d_reg[k-1];
                assign sb_i  = sb_reg[k-1];
            end

            assign dsh  = RW'(d_in) << J;
            assign ge_x = rx_in >= dsh;
            assign ge_y = ry_in >= dsh;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (en) begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    c_reg[k]  <= c_in;
                    qx_reg[k] <= qx_in | (QW'(ge_x) << J);
                    qy_reg[k] <= qy_in | (QW'(ge_y) << J);
                    sb_reg[k] <= sb_i;
                end
            end

            if (k < QW - 1) begin : g_rem
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rx_reg[k] <= ge_x ? rx_in - dsh : rx_in;
                        ry_reg[k] <= ge_y ? ry_in - dsh : ry_in;
                        d_reg[k]  <= d_in;
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        ctl_out       = c_reg[QW-1];
        ctl_out.valid = v_reg[QW-1];
    end

    assign q_x    = qx_reg[QW-1];
    assign q_y    = qy_reg[QW-1];
    assign sb_out = sb_reg[QW-1];

endmodule

// ----- design/spt_back.sv -----
// Back pipeline: foot point, distance test, saturation and the output register.
// Depends on spt_pkg.
module spt_back #(
    parameter int CW = spt_pkg::COORD_WIDTH_DEF,
    parameter int QW = CW + 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  spt_pkg::ctl_t                 ctl_in,
    input  logic [QW-1:0]                 q_x,
    input  logic [QW-1:0]                 q_y,
    input  logic signed [CW-1:0]          bx,
    input  logic signed [CW-1:0]          by,
    input  logic signed [CW-1:0]          px,
    input  logic signed [CW-1:0]          py,
    input  logic [spt_pkg::TOL_WIDTH-1:0] tol,
    output logic                          out_valid,
    output logic                          hit,
    output logic signed [CW-1:0]          nearest_x,
    output logic signed [CW-1:0]          nearest_y
);

    localparam int FW = QW + 1;
    localparam int EW = FW + 1;
    localparam int TW = spt_pkg::TOL_WIDTH;
    localparam int SW = spt_pkg::DIST_WIDTH;
    localparam logic signed [FW-1:0] HI = {{(FW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [FW-1:0] LO = {{(FW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [EW-1:0] DIST_MAX = EW'({SW{1'b1}});

    // ---------------- B1: foot point
    logic signed [FW-1:0] offx, offy, qxs, qys;
    logic                 calc;

    always_comb begin
        calc = ctl_in.kind == spt_pkg::KIND_CALC;
        qxs  = $signed({1'b0, q_x});
        qys  = $signed({1'b0, q_y});
        offx = calc ? (ctl_in.neg_x ? -qxs : qxs) : '0;
        offy = calc ? (ctl_in.neg_y ? -qys : qys) : '0;
    end

    logic                 v1_reg;
    spt_pkg::kind_t       k1_reg;
    logic signed [FW-1:0] fx1_reg, fy1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg;
    logic [TW-1:0]        t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg  <= ctl_in.kind;
            fx1_reg <= FW'(bx) + offx;
            fy1_reg <= FW'(by) + offy;
            px1_reg <= px;
            py1_reg <= py;
            t1_reg  <= tol;
        end
    end

    // ---------------- B2: component distances
    logic signed [EW-1:0] dx, dy;
    logic [EW-1:0]        mdx, mdy;

    always_comb begin
        dx  = EW'(px1_reg) - EW'(fx1_reg);
        dy  = EW'(py1_reg) - EW'(fy1_reg);
        mdx = dx[EW-1] ? EW'(-dx) : EW'(dx);
        mdy = dy[EW-1] ? EW'(-dy) : EW'(dy);
    end

    logic                 v2_reg, over2_reg;
    spt_pkg::kind_t       k2_reg;
    logic [SW-1:0]        adx_reg, ady_reg;
    logic signed [FW-1:0] fx2_reg, fy2_reg;
    logic [TW-1:0]        t2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k2_reg    <= k1_reg;
            over2_reg <= (mdx > DIST_MAX) || (mdy > DIST_MAX);
            adx_reg   <= mdx[SW-1:0];
            ady_reg   <= mdy[SW-1:0];
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            t2_reg    <= t1_reg;
        end
    end

    // ---------------- B3: squares
    logic                 v3_reg, over3_reg;
    spt_pkg::kind_t       k3_reg;
    logic [2*SW-1:0]      sqx_reg, sqy_reg;
    logic [2*TW-1:0]      tt_reg;
    logic signed [FW-1:0] fx3_reg, fy3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k3_reg    <= k2_reg;
            over3_reg <= over2_reg;
            sqx_reg   <= (2*SW)'(adx_reg) * (2*SW)'(adx_reg);
            sqy_reg   <= (2*SW)'(ady_reg) * (2*SW)'(ady_reg);
            tt_reg    <= (2*TW)'(t2_reg) * (2*TW)'(t2_reg);
            fx3_reg   <= fx2_reg;
            fy3_reg   <= fy2_reg;
        end
    end

    // ---------------- B4: decide, saturate, output register
    logic                 near, hit4;
    logic signed [CW-1:0] sx, sy;

    always_comb begin
        near = !over3_reg
            && ((2*SW+1)'(sqx_reg) + (2*SW+1)'(sqy_reg) < (2*SW+1)'(tt_reg));
        case (k3_reg)
            spt_pkg::KIND_END1,
            spt_pkg::KIND_END2:  hit4 = 1'b1;
            spt_pkg::KIND_NEARV,
            spt_pkg::KIND_NEARH,
            spt_pkg::KIND_CALC:  hit4 = near;
            default:             hit4 = 1'b0;
        endcase
        if (fx3_reg > HI) begin
            sx = HI[CW-1:0];
        end else if (fx3_reg < LO) begin
            sx = LO[CW-1:0];
        end else begin
            sx = fx3_reg[CW-1:0];
        end
        if (fy3_reg > HI) begin
            sy = HI[CW-1:0];
        end else if (fy3_reg < LO) begin
            sy = LO[CW-1:0];
        end else begin
            sy = fy3_reg[CW-1:0];
        end
    end

    logic                 vo_reg, hit_reg;
    logic signed [CW-1:0] nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg <= hit4;
            nx_reg  <= hit4 ? sx : '0;
            ny_reg  <= hit4 ? sy : '0;
        end
    end

    assign out_valid = vo_reg;
    assign hit       = hit_reg;
    assign nearest_x = nx_reg;
    assign nearest_y = ny_reg;

endmodule

// ----- design/segment_proximity_test.sv -----
// Top level of the segment proximity test: tolerance register and the
// front, divider and back pipelines. Depends on spt_pkg, spt_front, spt_div, spt_back.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: segment endpoints, query point
//  m_      | out | m_tvalid/m_tready | m_tdata: hit, nearest point
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data: tolerance
//
// One request enters per cycle unless a result held at m_ stalls the pipeline; the
// divider retires one quotient bit per stage.
// Reset clears all valid bits and loads the tolerance with 3.0.
// A result held at m_ stalls the whole pipeline in place; s_tready drops with it.
module segment_proximity_test #(
    parameter int COORD_WIDTH = spt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = spt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // hit, nearest_x, nearest_y
    output logic [((2*COORD_WIDTH+8)/8)*8-1:0]     m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [spt_pkg::TOL_WIDTH-1:0]          cfg_wr_data
);

    localparam int CW   = COORD_WIDTH;
    localparam int MDW  = ((2*COORD_WIDTH+8)/8)*8;
    localparam int QW   = CW + 2;
    localparam int NUMW = 3 * CW + 3;
    localparam int DENW = 2 * CW + 3;
    localparam int TW   = spt_pkg::TOL_WIDTH;
    localparam int SBW  = 4 * CW + TW;

    logic [TW-1:0] tol_reg;
    logic          en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= spt_pkg::TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    // advance everything unless the output holds an untaken result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    spt_pkg::ctl_t        f_ctl, d_ctl;
    logic [NUMW-1:0]      f_numx, f_numy;
    logic [DENW-1:0]      f_den;
    logic signed [CW-1:0] f_bx, f_by, f_px, f_py;
    logic [TW-1:0]        f_tol;
    logic [SBW-1:0]       d_sb;
    logic [QW-1:0]        d_qx, d_qy;
    logic                 o_hit;
    logic signed [CW-1:0] o_nx, o_ny;

    spt_front #(.CW(CW), .FB(FRAC_BITS), .NUMW(NUMW), .DENW(DENW)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .x1       (s_tdata[CW-1:0]),
        .y1       (s_tdata[2*CW-1:CW]),
        .x2       (s_tdata[3*CW-1:2*CW]),
        .y2       (s_tdata[4*CW-1:3*CW]),
        .xp       (s_tdata[5*CW-1:4*CW]),
        .yp       (s_tdata[6*CW-1:5*CW]),
        .tol      (tol_reg),
        .ctl_out  (f_ctl),
        .num_x    (f_numx),
        .num_y    (f_numy),
        .den2     (f_den),
        .bx_out   (f_bx),
        .by_out   (f_by),
        .px_out   (f_px),
        .py_out   (f_py),
        .tol_out  (f_tol)
    );

    spt_div #(.NUMW(NUMW), .DENW(DENW), .QW(QW), .SBW(SBW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (f_ctl),
        .num_x   (f_numx),
        .num_y   (f_numy),
        .den     (f_den),
        .sb_in   ({f_bx, f_by, f_px, f_py, f_tol}),
        .ctl_out (d_ctl),
        .q_x     (d_qx),
        .q_y     (d_qy),
        .sb_out  (d_sb)
    );

    spt_back #(.CW(CW), .QW(QW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .ctl_in    (d_ctl),
        .q_x       (d_qx),
        .q_y       (d_qy),
        .bx        (d_sb[SBW-1:3*CW+TW]),
        .by        (d_sb[3*CW+TW-1:2*CW+TW]),
        .px        (d_sb[2*CW+TW-1:CW+TW]),
        .py        (d_sb[CW+TW-1:TW]),
        .tol       (d_sb[TW-1:0]),
        .out_valid (m_tvalid),
        .hit       (o_hit),
        .nearest_x (o_nx),
        .nearest_y (o_ny)
    );

    assign m_tdata = MDW'({o_ny, o_nx, o_hit});

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[MDW-1:1] == '0)
        else $error("miss result carries a nonzero point");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output is stalled");

endmodule
